// ===== sv/scfm_pkg.sv =====
// Package with shared types and constants of the sensor current fault monitor.
package scfm_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned InDataW = 56;
	localparam int unsigned OutDataW = 8;

	localparam logic [7:0] VarLimit = 8'd20;
	localparam logic [15:0] RunLimit = 16'd60;
	localparam logic [15:0] RunMax = 16'hFFFF;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_CUR_LO   = 3'd0,
		CFG_CUR_HI   = 3'd1,
		CFG_WARM_END = 3'd2,
		CFG_HOLD     = 3'd3,
		CFG_GLU_LO   = 3'd4,
		CFG_GLU_HI   = 3'd5,
		CFG_EXPIRY   = 3'd6,
		CFG_MERGED   = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_NONE     = 4'd0,
		ST_WARMUP   = 4'd1,
		ST_HIGH     = 4'd2,
		ST_LOW      = 4'd3,
		ST_VAR      = 4'd4,
		ST_F_HIGH   = 4'd5,
		ST_F_LOW    = 4'd6,
		ST_F_VAR    = 4'd7,
		ST_ABNORMAL = 4'd8,
		ST_FAULT    = 4'd9,
		ST_EXPIRED  = 4'd10
	} status_t;

	typedef struct packed {
		logic [15:0] cur_lo;
		logic [15:0] cur_hi;
		logic [15:0] warm_end;
		logic [7:0]  hold;
		logic [11:0] glu_lo;
		logic [11:0] glu_hi;
		logic [15:0] expiry;
		logic        merged;
	} cfg_t;

	typedef struct packed {
		logic [15:0] reading_index;
		logic [11:0] glucose_level;
		logic [15:0] sensor_current;
		logic [7:0]  variation;
	} reading_t;

endpackage

// ===== sv/scfm_cfg_regs.sv =====
// Configuration register file of the sensor current fault monitor.
module scfm_cfg_regs import scfm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cur_lo   <= 16'd0;
			cfg_q.cur_hi   <= 16'hFFFF;
			cfg_q.warm_end <= 16'd40;
			cfg_q.hold     <= 8'd10;
			cfg_q.glu_lo   <= 12'd390;
			cfg_q.glu_hi   <= 12'd1000;
			cfg_q.expiry   <= 16'd6719;
			cfg_q.merged   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CUR_LO:   cfg_q.cur_lo   <= cfg_wdata;
				CFG_CUR_HI:   cfg_q.cur_hi   <= cfg_wdata;
				CFG_WARM_END: cfg_q.warm_end <= cfg_wdata;
				CFG_HOLD:     cfg_q.hold     <= cfg_wdata[7:0];
				CFG_GLU_LO:   cfg_q.glu_lo   <= cfg_wdata[11:0];
				CFG_GLU_HI:   cfg_q.glu_hi   <= cfg_wdata[11:0];
				CFG_EXPIRY:   cfg_q.expiry   <= cfg_wdata;
				CFG_MERGED:   cfg_q.merged   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/scfm_update.sv =====
// Status, hold and error-run registers with the per-reading update logic.
module scfm_update import scfm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  reading_t rd,
	input  cfg_t     cfg,
	output status_t  status
);

	status_t     status_q, status_d;
	logic [7:0]  hold_q, hold_d;
	logic [15:0] run_q, run_d;
	logic        too_low, too_high, bad_var, glu_out, latched;
	logic [15:0] run_inc;

	assign too_low  = rd.sensor_current <= cfg.cur_lo;
	assign too_high = rd.sensor_current >= cfg.cur_hi;
	assign bad_var  = rd.variation >= VarLimit;
	assign glu_out  = (rd.glucose_level < cfg.glu_lo) || (rd.glucose_level > cfg.glu_hi);
	assign latched  = (status_q == ST_F_HIGH) || (status_q == ST_F_LOW) ||
	                  (status_q == ST_F_VAR) || (status_q == ST_FAULT);
	assign run_inc  = (run_q == RunMax) ? run_q : run_q + 16'd1;

	always_comb begin
		status_d = status_q;
		hold_d   = hold_q;
		run_d    = run_q;
		if (rd.reading_index <= 16'd1) begin
			status_d = ST_WARMUP;
			hold_d   = 8'd0;
			run_d    = 16'd0;
		end else if (!latched) begin
			if (rd.reading_index < cfg.warm_end) begin
				if (!too_low && !too_high) begin
					if (hold_q != 8'd0) begin
						hold_d = hold_q - 8'd1;
					end else begin
						status_d = ST_WARMUP;
					end
					run_d = 16'd0;
				end else begin
					// In detailed mode a current outside both limits reports low.
					if (cfg.merged) begin
						status_d = ST_ABNORMAL;
					end else if (too_low) begin
						status_d = ST_LOW;
					end else begin
						status_d = ST_HIGH;
					end
					hold_d = cfg.hold;
					run_d  = run_inc;
				end
			end else if ((bad_var || too_low || too_high) && glu_out) begin
				run_d = run_inc;
				if (run_inc >= RunLimit) begin
					if (cfg.merged) begin
						status_d = ST_FAULT;
					end else if (too_high) begin
						status_d = ST_F_HIGH;
					end else if (too_low) begin
						status_d = ST_F_LOW;
					end else begin
						status_d = ST_F_VAR;
					end
				end else begin
					if (cfg.merged) begin
						status_d = ST_ABNORMAL;
					end else if (too_high) begin
						status_d = ST_HIGH;
					end else if (too_low) begin
						status_d = ST_LOW;
					end else begin
						status_d = ST_VAR;
					end
				end
			end else begin
				run_d    = 16'd0;
				status_d = ST_NONE;
			end
		end
		if (rd.reading_index == cfg.expiry) begin
			status_d = ST_EXPIRED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_NONE;
			hold_q   <= 8'd0;
			run_q    <= 16'd0;
		end else if (en) begin
			status_q <= status_d;
			hold_q   <= hold_d;
			run_q    <= run_d;
		end
	end

	assign status = status_q;

endmodule

// ===== sv/sensor_current_fault_monitor_unit.sv =====
// Top level of the sensor current fault monitor.
// A reading passes through the input register and then the status register before its status is on m_tdata.
// Throughput: one reading per cycle while m_tready holds the output side open, set by the state update loop.
// The input register and the status register let a new reading enter while a
// finished status still waits on the output side.
// Reset clears the state, the valid flags and restores the register defaults.
module sensor_current_fault_monitor_unit import scfm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// Fields from bit 0: reading_index[15:0], glucose_level[27:16],
	// sensor_current[43:28], variation[51:44], zero pad [55:52].
	input  logic [InDataW-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// Fields from bit 0: reading_status[3:0], zero pad [7:4].
	output logic [OutDataW-1:0] m_tdata,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	cfg_t     cfg;
	reading_t rd_s1;
	logic     valid_s1;
	logic     valid_s2;
	logic     advance;
	status_t  status;

	// The status register can take a new reading once its current one is gone.
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rd_s1.reading_index  <= s_tdata[15:0];
			rd_s1.glucose_level  <= s_tdata[27:16];
			rd_s1.sensor_current <= s_tdata[43:28];
			rd_s1.variation      <= s_tdata[51:44];
		end
	end

	scfm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	scfm_update u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance && valid_s1),
		.rd     (rd_s1),
		.cfg    (cfg),
		.status (status)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, status};

endmodule

// ===== sv/scfm_checker.sv =====
// Port-level checker of the sensor current fault monitor, bound to the top level.
module scfm_checker import scfm_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OutDataW-1:0] m_tdata
);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:4] == 4'd0) && (m_tdata[3:0] <= 4'd10))
		else $error("status code out of range");

	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output side is empty");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output transfer changed");

	a_ready_after_out_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |-> s_tready)
		else $error("input stalled while output transfer completes");

endmodule

bind sensor_current_fault_monitor_unit scfm_checker u_scfm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/tb.sv =====
// Testbench for the sensor current fault monitor: directed and random readings checked against a predictor.
module tb;
	import scfm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {BAD_VAR, BAD_LOW, BAD_HIGH} bad_kind_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	// Fields from bit 0: reading_index[15:0], glucose_level[27:16],
	// sensor_current[43:28], variation[51:44], zero pad [55:52].
	logic [InDataW-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	// Fields from bit 0: reading_status[3:0], zero pad [7:4].
	logic [OutDataW-1:0] m_tdata;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_wdata;

	// Predictor state and its copy of the registers.
	cfg_t        mon_cfg;
	status_t     mon_status;
	logic [7:0]  mon_hold;
	logic [15:0] mon_run;

	status_t     pending_status[$];
	int          mismatches;
	bit          no_gaps;
	int          rx_hold_cycles;

	sensor_current_fault_monitor_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic status_t predict_status(reading_t r);
		logic too_low, too_high, bad_var, glu_out;
		too_low  = r.sensor_current <= mon_cfg.cur_lo;
		too_high = r.sensor_current >= mon_cfg.cur_hi;
		if (r.reading_index <= 16'd1) begin
			mon_status = ST_WARMUP;
			mon_hold   = '0;
			mon_run    = '0;
		end else if (!(mon_status inside {ST_F_HIGH, ST_F_LOW, ST_F_VAR, ST_FAULT})) begin
			if (r.reading_index < mon_cfg.warm_end) begin
				if (!too_low && !too_high) begin
					if (mon_hold != 0)
						mon_hold = mon_hold - 8'd1;
					else
						mon_status = ST_WARMUP;
					mon_run = '0;
				end else begin
					if (mon_cfg.merged)
						mon_status = ST_ABNORMAL;
					else if (too_low)
						mon_status = ST_LOW;
					else
						mon_status = ST_HIGH;
					mon_hold = mon_cfg.hold;
					if (mon_run != RunMax)
						mon_run = mon_run + 16'd1;
				end
			end else begin
				bad_var = r.variation >= VarLimit;
				glu_out = r.glucose_level < mon_cfg.glu_lo || r.glucose_level > mon_cfg.glu_hi;
				if ((bad_var || too_low || too_high) && glu_out) begin
					if (mon_run != RunMax)
						mon_run = mon_run + 16'd1;
					if (mon_cfg.merged)
						mon_status = ST_ABNORMAL;
					else if (too_high)
						mon_status = ST_HIGH;
					else if (too_low)
						mon_status = ST_LOW;
					else
						mon_status = ST_VAR;
					if (mon_run >= RunLimit) begin
						if (mon_cfg.merged) begin
							mon_status = ST_FAULT;
						end else begin
							case (mon_status)
								ST_VAR:  mon_status = ST_F_VAR;
								ST_HIGH: mon_status = ST_F_HIGH;
								ST_LOW:  mon_status = ST_F_LOW;
								default: ;
							endcase
						end
					end
				end else begin
					mon_run    = '0;
					mon_status = ST_NONE;
				end
			end
		end
		// Expiry wins over everything else and is stored.
		if (r.reading_index == mon_cfg.expiry)
			mon_status = ST_EXPIRED;
		return mon_status;
	endfunction

	function automatic reading_t reading_of(int unsigned idx, int unsigned glu,
			int unsigned cur, int unsigned vari);
		reading_t r;
		r.reading_index  = idx[15:0];
		r.glucose_level  = glu[11:0];
		r.sensor_current = cur[15:0];
		r.variation      = vari[7:0];
		return r;
	endfunction

	function automatic cfg_t make_cfg(int unsigned lo, int unsigned hi, int unsigned warm,
			int unsigned hold, int unsigned glo, int unsigned ghi, int unsigned expiry,
			bit merged);
		cfg_t c;
		c.cur_lo   = lo[15:0];
		c.cur_hi   = hi[15:0];
		c.warm_end = warm[15:0];
		c.hold     = hold[7:0];
		c.glu_lo   = glo[11:0];
		c.glu_hi   = ghi[11:0];
		c.expiry   = expiry[15:0];
		c.merged   = merged;
		return c;
	endfunction

	function automatic logic [11:0] glucose_outside();
		if (mon_cfg.glu_lo > 0 && (mon_cfg.glu_hi >= 12'd4000 || $urandom_range(0, 1)))
			return 12'($urandom_range(0, mon_cfg.glu_lo - 1));
		else if (mon_cfg.glu_hi < 12'd4000)
			return 12'($urandom_range(mon_cfg.glu_hi + 1, 4000));
		else
			return 12'($urandom_range(0, 4000));
	endfunction

	function automatic reading_t good_reading(int unsigned idx);
		reading_t r;
		r = reading_of(idx, $urandom_range(0, 4000), $urandom_range(0, 65535),
			$urandom_range(0, 19));
		if (int'(mon_cfg.cur_hi) - int'(mon_cfg.cur_lo) >= 2)
			r.sensor_current = 16'($urandom_range(mon_cfg.cur_lo + 1, mon_cfg.cur_hi - 1));
		return r;
	endfunction

	function automatic reading_t bad_reading(int unsigned idx, bad_kind_t kind);
		reading_t r;
		r = good_reading(idx);
		r.glucose_level = glucose_outside();
		case (kind)
			BAD_VAR:  r.variation = 8'($urandom_range(20, 255));
			BAD_LOW:  r.sensor_current = 16'($urandom_range(0, mon_cfg.cur_lo));
			BAD_HIGH: r.sensor_current = 16'($urandom_range(mon_cfg.cur_hi, 65535));
			default: ;
		endcase
		return r;
	endfunction

	// Entered and left at a falling edge.
	task automatic send_reading(reading_t r);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, r.variation, r.sensor_current, r.glucose_level, r.reading_index};
		do @(posedge clk); while (!s_tready);
		pending_status.push_back(predict_status(r));
		@(negedge clk);
	endtask

	// Waits until every status has come back and the pipeline is empty.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_status.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		case (idx)
			CFG_CUR_LO:   mon_cfg.cur_lo   = val;
			CFG_CUR_HI:   mon_cfg.cur_hi   = val;
			CFG_WARM_END: mon_cfg.warm_end = val;
			CFG_HOLD:     mon_cfg.hold     = val[7:0];
			CFG_GLU_LO:   mon_cfg.glu_lo   = val[11:0];
			CFG_GLU_HI:   mon_cfg.glu_hi   = val[11:0];
			CFG_EXPIRY:   mon_cfg.expiry   = val;
			CFG_MERGED:   mon_cfg.merged   = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_config(cfg_t c);
		settle();
		write_reg(CFG_CUR_LO, c.cur_lo);
		write_reg(CFG_CUR_HI, c.cur_hi);
		write_reg(CFG_WARM_END, c.warm_end);
		write_reg(CFG_HOLD, {8'b0, c.hold});
		write_reg(CFG_GLU_LO, {4'b0, c.glu_lo});
		write_reg(CFG_GLU_HI, {4'b0, c.glu_hi});
		write_reg(CFG_EXPIRY, c.expiry);
		write_reg(CFG_MERGED, {15'b0, c.merged});
		cfg_we <= 1'b0;
	endtask

	// Readings under the register values left by reset.
	task automatic test_defaults();
		send_reading(reading_of(0, 0, 1000, 0));
		send_reading(reading_of(2, 500, 0, 0));
		send_reading(reading_of(3, 500, 65535, 255));
		send_reading(reading_of(4, 500, 500, 0));
		send_reading(reading_of(40, 2047, 1234, 19));
		send_reading(reading_of(41, 389, 1234, 20));
		send_reading(reading_of(42, 1001, 0, 255));
		send_reading(reading_of(43, 4000, 65535, 255));
		send_reading(reading_of(44, 390, 65535, 255));
		send_reading(reading_of(45, 1000, 0, 255));
		send_reading(reading_of(46, 0, 1234, 0));
		send_reading(reading_of(6719, 0, 1234, 255));
		send_reading(reading_of(6720, 700, 1234, 0));
		send_reading(reading_of(65535, 0, 65535, 255));
		send_reading(reading_of(1, 4000, 0, 255));
	endtask

	task automatic test_warmup_hold();
		apply_config(make_cfg(100, 200, 65535, 2, 390, 1000, 0, 0));
		// An expiry index of zero overrides the restart itself.
		send_reading(reading_of(0, 500, 150, 0));
		send_reading(reading_of(2, 500, 150, 0));
		send_reading(reading_of(3, 500, 100, 0));
		send_reading(reading_of(4, 500, 150, 0));
		send_reading(reading_of(5, 500, 150, 0));
		send_reading(reading_of(6, 500, 150, 0));
		send_reading(reading_of(7, 500, 200, 0));
		send_reading(reading_of(65534, 3000, 199, 255));
	endtask

	task automatic test_empty_window();
		apply_config(make_cfg(300, 300, 4, 0, 390, 1000, 65535, 0));
		send_reading(reading_of(0, 500, 300, 0));
		send_reading(reading_of(2, 500, 300, 0));
		send_reading(reading_of(3, 500, 301, 0));
		send_reading(reading_of(4, 100, 300, 0));
		send_reading(reading_of(5, 500, 300, 0));
		send_reading(reading_of(6, 4000, 299, 50));
		send_reading(reading_of(65535, 4000, 0, 0));
	endtask

	task automatic test_fault_latch();
		bad_kind_t kind;
		apply_config(make_cfg(1000, 50000, 2, 10, 390, 1000, 500, 0));
		for (int k = 0; k < 3; k++) begin
			kind = bad_kind_t'(k);
			send_reading(reading_of(0, 500, 2000, 0));
			for (int i = 2; i < 64; i++)
				send_reading(bad_reading(i, kind));
			// Latched: a good reading keeps the fault.
			send_reading(good_reading(64));
		end
		// Expiry replaces a latched fault, and the next reading clears it.
		send_reading(good_reading(500));
		send_reading(good_reading(501));
	endtask

	task automatic test_merged_codes();
		apply_config(make_cfg(1000, 50000, 3, 5, 390, 1000, 65535, 1));
		send_reading(reading_of(1, 500, 2000, 0));
		send_reading(reading_of(2, 500, 0, 0));
		for (int i = 3; i < 65; i++)
			send_reading(bad_reading(i, bad_kind_t'($urandom_range(0, 2))));
		apply_config(make_cfg(1000, 50000, 3, 5, 390, 1000, 65535, 0));
		for (int i = 65; i < 68; i++)
			send_reading(good_reading(i));
		send_reading(reading_of(1, 500, 2000, 0));
	endtask

	// The status side stops for a long stretch while readings keep coming.
	task automatic test_backpressure();
		apply_config(make_cfg(2000, 40000, 10, 3, 390, 1000, 45, 0));
		rx_hold_cycles = 300;
		no_gaps = 1'b1;
		send_reading(reading_of(0, 500, 5000, 0));
		for (int i = 2; i < 62; i++) begin
			if ($urandom_range(0, 1))
				send_reading(bad_reading(i, bad_kind_t'($urandom_range(0, 2))));
			else
				send_reading(good_reading(i));
		end
		no_gaps = 1'b0;
	endtask

	task automatic random_readings(int count);
		int unsigned idx;
		int          streak;
		bit          streak_bad;
		int          roll;
		reading_t    r;
		idx = $urandom_range(0, 1);
		streak = 0;
		streak_bad = 1'b0;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			// Bad streaks are long enough to reach the fault latch now and then.
			if (streak == 0) begin
				streak_bad = $urandom_range(0, 1);
				streak = streak_bad ? $urandom_range(1, 90) : $urandom_range(1, 25);
			end
			streak--;
			roll = $urandom_range(0, 999);
			if (roll < 5)
				idx = $urandom_range(0, 1);
			else if (roll < 15 && mon_cfg.expiry >= 2)
				idx = mon_cfg.expiry;
			if (roll >= 15 && roll < 75)
				r = reading_of($urandom_range(0, 65535), $urandom_range(0, 4000),
					$urandom_range(0, 65535), $urandom_range(0, 255));
			else if (streak_bad)
				r = bad_reading(idx, bad_kind_t'($urandom_range(0, 2)));
			else
				r = good_reading(idx);
			send_reading(r);
			if (idx < 65535)
				idx++;
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_random();
		cfg_t c;
		int unsigned lo, glo;
		for (int p = 0; p < 8; p++) begin
			if (p == 0) begin
				c = make_cfg(0, 0, 0, 0, 0, 0, 0, 0);
			end else if (p == 7) begin
				c = make_cfg(65535, 65535, 65535, 255, 4000, 4000, 65535, 1);
			end else begin
				lo  = $urandom_range(0, 30000);
				glo = $urandom_range(0, 2000);
				c = make_cfg(lo, lo + $urandom_range(2, 30000), $urandom_range(0, 100),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12),
					glo, glo + $urandom_range(0, 2000),
					($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(2, 400),
					$urandom_range(0, 1));
			end
			apply_config(c);
			random_readings(180);
		end
	endtask

	initial begin : status_sink
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rx_hold_cycles != 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else begin
				stall = no_gaps ? 0 : $urandom_range(0, 8);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (pending_status.size() == 0) begin
				$display("%0t: status %0d arrived with none expected", $time, m_tdata[3:0]);
				mismatches++;
			end else begin
				status_t want;
				want = pending_status.pop_front();
				if (m_tdata[3:0] != want) begin
					$display("%0t: reading_status expected %0d (%s) got %0d",
						$time, want, want.name(), m_tdata[3:0]);
					mismatches++;
				end
			end
			@(negedge clk);
		end
	end

	initial begin
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_CUR_LO;
		cfg_wdata = '0;
		mismatches = 0;
		no_gaps = 1'b0;
		rx_hold_cycles = 0;
		mon_cfg = make_cfg(0, 65535, 40, 10, 390, 1000, 6719, 0);
		mon_status = ST_NONE;
		mon_hold = '0;
		mon_run = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_defaults();
		test_warmup_hold();
		test_empty_window();
		test_fault_latch();
		test_merged_codes();
		test_backpressure();
		test_random();

		settle();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
